// ----- hdl/mqm_pkg.sv -----
// Shared types, codes and the frequency table for the mains quality monitor.
`timescale 1ns / 1ps

package mqm_pkg;

    // item kinds
    localparam logic [1:0] FUNC_INIT  = 2'd0;
    localparam logic [1:0] FUNC_CROSS = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // status codes, shared by raw and debounced status
    localparam logic [2:0] ST_UNKNOWN = 3'd0;
    localparam logic [2:0] ST_GOOD    = 3'd1;
    localparam logic [2:0] ST_LOST    = 3'd2;
    localparam logic [2:0] ST_LOW     = 3'd3;
    localparam logic [2:0] ST_HIGH    = 3'd4;
    localparam logic [2:0] ST_FREQ    = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_VOLT_LOW    = 3'd0;
    localparam logic [2:0] REG_VOLT_HIGH   = 3'd1;
    localparam logic [2:0] REG_VOLT_MARGIN = 3'd2;
    localparam logic [2:0] REG_FREQ_LOW    = 3'd3;
    localparam logic [2:0] REG_FREQ_HIGH   = 3'd4;
    localparam logic [2:0] REG_FAIL_DEB    = 3'd5;
    localparam logic [2:0] REG_GOOD_DEB    = 3'd6;

    // timing and level constants
    localparam logic [4:0]  CROSS_MIN_MS   = 5'd6;
    localparam logic [4:0]  CROSS_MAX_MS   = 5'd25;
    localparam logic [5:0]  LOST_MS        = 6'd60;
    localparam logic [11:0] LOST_VOLT      = 12'd500;
    localparam logic [4:0]  HALF_PERIOD_RST = 5'd10;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic [11:0] volt_rms;
    } item_t;

    typedef struct packed {
        logic        phase_lock;
        logic [2:0]  raw_status;
        logic [2:0]  debounced_status;
        logic        warn_abnormal;
        logic [13:0] freq_centihz;
    } result_t;

    typedef struct packed {
        logic [11:0] volt_low_limit;
        logic [11:0] volt_high_limit;
        logic [11:0] volt_recovery_margin;
        logic [13:0] freq_low_limit;
        logic [13:0] freq_high_limit;
        logic [15:0] fail_debounce_ms;
        logic [15:0] good_debounce_ms;
    } cfg_t;

    // floor(50000 / n); half-periods below 6 never occur and read as 0
    function automatic logic [13:0] freq_lookup(input logic [4:0] half_ms);
        logic [13:0] f;
        unique case (half_ms)
            5'd6:    f = 14'd8333;
            5'd7:    f = 14'd7142;
            5'd8:    f = 14'd6250;
            5'd9:    f = 14'd5555;
            5'd10:   f = 14'd5000;
            5'd11:   f = 14'd4545;
            5'd12:   f = 14'd4166;
            5'd13:   f = 14'd3846;
            5'd14:   f = 14'd3571;
            5'd15:   f = 14'd3333;
            5'd16:   f = 14'd3125;
            5'd17:   f = 14'd2941;
            5'd18:   f = 14'd2777;
            5'd19:   f = 14'd2631;
            5'd20:   f = 14'd2500;
            5'd21:   f = 14'd2380;
            5'd22:   f = 14'd2272;
            5'd23:   f = 14'd2173;
            5'd24:   f = 14'd2083;
            5'd25:   f = 14'd2000;
            5'd26:   f = 14'd1923;
            5'd27:   f = 14'd1851;
            5'd28:   f = 14'd1785;
            5'd29:   f = 14'd1724;
            5'd30:   f = 14'd1666;
            5'd31:   f = 14'd1612;
            default: f = 14'd0;
        endcase
        return f;
    endfunction

endpackage

// ----- hdl/mains_quality_monitor.sv -----
// Top level of the mains quality monitor: handshake, configuration registers, output word.
//
// Usage:
//   Input words (item) carry a kind (init, zero crossing, control tick), the
//   millisecond time and the RMS voltage. Each input word yields exactly one
//   result word: phase-lock pulse, raw class, debounced status, warning flag
//   and derived frequency in centi-hertz.
//   A word is taken when item_valid is high and item_stall is low; a result
//   is taken when result_valid is high and result_stall is low.
//   An input word that is taken is held in the input register, and the
//   classification and debounce logic loads the result register from it,
//   raising result_valid. Throughput is one word per cycle while the receiver
//   does not stall; the output register refills on the same edge it empties.
//   When the receiver stalls, the result holds, the input register holds its
//   word, and item_stall rises once both are full.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
//   edge; write them only while no word is in flight.
//   Reset clears both stages, restores the register defaults and returns the
//   monitor to unknown status with a 10 ms half-period.
`timescale 1ns / 1ps

module mains_quality_monitor #(
    parameter int TIME_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mqm_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output mqm_pkg::result_t  result,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    mqm_pkg::cfg_t    cfg_reg;
    mqm_pkg::item_t   in_word_reg;
    logic             in_valid_reg;
    mqm_pkg::result_t res_word_reg;
    logic             res_valid_reg;
    mqm_pkg::result_t res_next;
    logic             advance;
    logic             out_free;

    assign out_free   = !res_valid_reg || !result_stall;
    assign advance    = in_valid_reg && out_free;
    assign item_stall = in_valid_reg && !out_free;

    assign result_valid = res_valid_reg;
    assign result       = res_word_reg;

    mqm_core #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .item   (in_word_reg),
        .cfg    (cfg_reg),
        .result (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (!result_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            in_word_reg <= item;
        if (advance)
            res_word_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volt_low_limit       <= 12'd1760;
            cfg_reg.volt_high_limit      <= 12'd2640;
            cfg_reg.volt_recovery_margin <= 12'd50;
            cfg_reg.freq_low_limit       <= 14'd4500;
            cfg_reg.freq_high_limit      <= 14'd5500;
            cfg_reg.fail_debounce_ms     <= 16'd20;
            cfg_reg.good_debounce_ms     <= 16'd3000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mqm_pkg::REG_VOLT_LOW:    cfg_reg.volt_low_limit       <= cfg_data[11:0];
                mqm_pkg::REG_VOLT_HIGH:   cfg_reg.volt_high_limit      <= cfg_data[11:0];
                mqm_pkg::REG_VOLT_MARGIN: cfg_reg.volt_recovery_margin <= cfg_data[11:0];
                mqm_pkg::REG_FREQ_LOW:    cfg_reg.freq_low_limit       <= cfg_data[13:0];
                mqm_pkg::REG_FREQ_HIGH:   cfg_reg.freq_high_limit      <= cfg_data[13:0];
                mqm_pkg::REG_FAIL_DEB:    cfg_reg.fail_debounce_ms     <= cfg_data;
                mqm_pkg::REG_GOOD_DEB:    cfg_reg.good_debounce_ms     <= cfg_data;
                default:
                begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

endmodule

// ----- hdl/mqm_core.sv -----
// Monitor state, classification and debounce; updates state when a word advances.
`timescale 1ns / 1ps

module mqm_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  mqm_pkg::item_t  item,
    input  mqm_pkg::cfg_t   cfg,
    output mqm_pkg::result_t result
);

    logic [TIME_WIDTH-1:0] last_cross_reg, last_cross_next;
    logic [4:0]            half_reg, half_next;
    logic [TIME_WIDTH-1:0] bad_start_reg, bad_start_next;
    logic [TIME_WIDTH-1:0] good_start_reg, good_start_next;
    logic                  good_started_reg, good_started_next;
    logic                  was_bad_reg, was_bad_next;
    logic [2:0]            raw_reg, raw_next;
    logic [2:0]            status_reg, status_next;
    logic                  warn_reg, warn_next;

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] since_cross;
    logic [TIME_WIDTH-1:0] bad_start_eff;
    logic [TIME_WIDTH-1:0] good_start_eff;
    logic [TIME_WIDTH-1:0] bad_elapsed;
    logic [TIME_WIDTH-1:0] good_elapsed;
    logic                  cross_ok;
    logic [13:0]           freq_cur;
    logic [2:0]            tick_class;
    logic [12:0]           recover_level;
    logic                  lock;

    assign now_t       = TIME_WIDTH'(item.now_ms);
    assign since_cross = now_t - last_cross_reg;
    assign cross_ok    = (since_cross >= TIME_WIDTH'(mqm_pkg::CROSS_MIN_MS)) &&
                         (since_cross <= TIME_WIDTH'(mqm_pkg::CROSS_MAX_MS));
    assign freq_cur    = mqm_pkg::freq_lookup(half_reg);

    // a fault or good period that starts on this tick starts now
    assign bad_start_eff  = was_bad_reg ? bad_start_reg : now_t;
    assign good_start_eff = good_started_reg ? good_start_reg : now_t;
    assign bad_elapsed    = now_t - bad_start_eff;
    assign good_elapsed   = now_t - good_start_eff;
    assign recover_level  = {1'b0, cfg.volt_low_limit} + {1'b0, cfg.volt_recovery_margin};

    always_comb
    begin
        priority if (since_cross > TIME_WIDTH'(mqm_pkg::LOST_MS) ||
                     item.volt_rms < mqm_pkg::LOST_VOLT)
            tick_class = mqm_pkg::ST_LOST;
        else if (item.volt_rms < cfg.volt_low_limit)
            tick_class = mqm_pkg::ST_LOW;
        else if (item.volt_rms > cfg.volt_high_limit)
            tick_class = mqm_pkg::ST_HIGH;
        else if (freq_cur < cfg.freq_low_limit || freq_cur > cfg.freq_high_limit)
            tick_class = mqm_pkg::ST_FREQ;
        else
            tick_class = mqm_pkg::ST_GOOD;
    end

    always_comb
    begin
        last_cross_next   = last_cross_reg;
        half_next         = half_reg;
        bad_start_next    = bad_start_reg;
        good_start_next   = good_start_reg;
        good_started_next = good_started_reg;
        was_bad_next      = was_bad_reg;
        raw_next          = raw_reg;
        status_next       = status_reg;
        warn_next         = warn_reg;
        lock              = 1'b0;

        unique case (item.func)
            mqm_pkg::FUNC_INIT:
            begin
                last_cross_next = now_t;
                status_next     = mqm_pkg::ST_UNKNOWN;
            end
            mqm_pkg::FUNC_CROSS:
            begin
                if (cross_ok)
                begin
                    half_next       = since_cross[4:0];
                    last_cross_next = now_t;
                    lock            = 1'b1;
                end
            end
            mqm_pkg::FUNC_TICK:
            begin
                raw_next = tick_class;
                if (tick_class != mqm_pkg::ST_GOOD)
                begin
                    good_started_next = 1'b0;
                    good_start_next   = '0;
                    bad_start_next    = bad_start_eff;
                    was_bad_next      = 1'b1;
                    if (bad_elapsed >= TIME_WIDTH'(cfg.fail_debounce_ms))
                    begin
                        status_next = tick_class;
                        warn_next   = 1'b1;
                    end
                end
                else
                begin
                    was_bad_next      = 1'b0;
                    good_start_next   = good_start_eff;
                    good_started_next = 1'b1;
                    if ({1'b0, item.volt_rms} > recover_level &&
                        good_elapsed >= TIME_WIDTH'(cfg.good_debounce_ms))
                    begin
                        status_next = mqm_pkg::ST_GOOD;
                        warn_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                // unused kind: hold everything
            end
        endcase
    end

    // frequency follows the half-period as it stands after this word
    assign result.phase_lock       = lock;
    assign result.raw_status       = raw_next;
    assign result.debounced_status = status_next;
    assign result.warn_abnormal    = warn_next;
    assign result.freq_centihz     = mqm_pkg::freq_lookup(half_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_cross_reg   <= '0;
            half_reg         <= mqm_pkg::HALF_PERIOD_RST;
            bad_start_reg    <= '0;
            good_start_reg   <= '0;
            good_started_reg <= 1'b0;
            was_bad_reg      <= 1'b0;
            raw_reg          <= mqm_pkg::ST_UNKNOWN;
            status_reg       <= mqm_pkg::ST_UNKNOWN;
            warn_reg         <= 1'b0;
        end
        else if (advance)
        begin
            last_cross_reg   <= last_cross_next;
            half_reg         <= half_next;
            bad_start_reg    <= bad_start_next;
            good_start_reg   <= good_start_next;
            good_started_reg <= good_started_next;
            was_bad_reg      <= was_bad_next;
            raw_reg          <= raw_next;
            status_reg       <= status_next;
            warn_reg         <= warn_next;
        end
    end

endmodule

// ----- tb/mains_quality_monitor_tb.sv -----
// Self-checking testbench for the mains quality monitor: directed table, then random traffic.
`timescale 1ns / 1ps

module mains_quality_monitor_tb;

    localparam logic [1:0]    FUNC_SPARE       = 2'd3;
    localparam int            N_PHASES         = 6;
    localparam int            RANDOM_PER_PHASE = 240;
    localparam int            HOLD_CYCLES      = 80;
    localparam int            DRAIN_CYCLES     = 4;
    localparam longint        WATCHDOG_NS      = 8_000_000;
    localparam mqm_pkg::cfg_t RESET_LIMITS     = '{12'd1760, 12'd2640, 12'd50, 14'd4500,
                                                   14'd5500, 16'd20, 16'd3000};

    typedef struct {
        mqm_pkg::item_t   word;
        bit               typed;
        mqm_pkg::result_t want;
    } stim_row_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    mqm_pkg::item_t   item;
    logic             result_valid;
    logic             result_stall;
    mqm_pkg::result_t result;
    logic             cfg_we;
    logic [2:0]       cfg_index;
    logic [15:0]      cfg_data;

    // monitor state as the testbench tracks it
    mqm_pkg::cfg_t lim           = RESET_LIMITS;
    logic [31:0]   last_cross_ms = '0;
    logic [4:0]    half_ms       = mqm_pkg::HALF_PERIOD_RST;
    logic [31:0]   bad_since_ms  = '0;
    logic [31:0]   good_since_ms = '0;
    bit            good_running  = 1'b0;
    bit            fault_pending = 1'b0;
    logic [2:0]    class_now     = mqm_pkg::ST_UNKNOWN;
    logic [2:0]    status_now    = mqm_pkg::ST_UNKNOWN;
    logic          warn_now      = 1'b0;

    mqm_pkg::result_t predicted_reports[$];
    stim_row_t        directed_rows[$];
    int               mismatches      = 0;
    int               words_sent      = 0;
    int               locks_seen      = 0;
    int               faults_seen     = 0;
    int               recoveries_seen = 0;
    int               burst_left      = 0;
    bit               hold_request    = 1'b0;
    bit               hold_done       = 1'b0;
    bit               healthy         = 1'b1;
    logic [31:0]      stamp_ms        = '0;
    logic [4:0]       mains_half      = 5'd10;

    mains_quality_monitor u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [13:0] centihz(input logic [4:0] h);
        return (h < mqm_pkg::CROSS_MIN_MS) ? 14'd0 : 14'(32'd50000 / h);
    endfunction

    // Advance the tracked monitor state by one word and form its report.
    task automatic monitor_step(input mqm_pkg::item_t w, output mqm_pkg::result_t r);
        logic [31:0] since_cross;
        logic [31:0] held_ms;
        logic [13:0] f;
        logic [12:0] recover_level;
        logic        lock;
        lock = 1'b0;
        f = centihz(half_ms);
        since_cross = w.now_ms - last_cross_ms;
        case (w.func)
            mqm_pkg::FUNC_INIT:
            begin
                last_cross_ms = w.now_ms;
                status_now = mqm_pkg::ST_UNKNOWN;
            end
            mqm_pkg::FUNC_CROSS:
            begin
                if (since_cross >= mqm_pkg::CROSS_MIN_MS &&
                    since_cross <= mqm_pkg::CROSS_MAX_MS)
                begin
                    half_ms = since_cross[4:0];
                    last_cross_ms = w.now_ms;
                    lock = 1'b1;
                    locks_seen++;
                    f = centihz(half_ms);
                end
            end
            mqm_pkg::FUNC_TICK:
            begin
                if (since_cross > mqm_pkg::LOST_MS || w.volt_rms < mqm_pkg::LOST_VOLT)
                    class_now = mqm_pkg::ST_LOST;
                else if (w.volt_rms < lim.volt_low_limit)
                    class_now = mqm_pkg::ST_LOW;
                else if (w.volt_rms > lim.volt_high_limit)
                    class_now = mqm_pkg::ST_HIGH;
                else if (f < lim.freq_low_limit || f > lim.freq_high_limit)
                    class_now = mqm_pkg::ST_FREQ;
                else
                    class_now = mqm_pkg::ST_GOOD;
                recover_level = 13'(lim.volt_low_limit) + 13'(lim.volt_recovery_margin);
                if (class_now != mqm_pkg::ST_GOOD)
                begin
                    good_running = 1'b0;
                    good_since_ms = '0;
                    if (!fault_pending)
                    begin
                        bad_since_ms = w.now_ms;
                        fault_pending = 1'b1;
                    end
                    held_ms = w.now_ms - bad_since_ms;
                    if (held_ms >= 32'(lim.fail_debounce_ms))
                    begin
                        if (status_now != class_now)
                            faults_seen++;
                        status_now = class_now;
                        warn_now = 1'b1;
                    end
                end
                else
                begin
                    fault_pending = 1'b0;
                    if (!good_running)
                    begin
                        good_since_ms = w.now_ms;
                        good_running = 1'b1;
                    end
                    held_ms = w.now_ms - good_since_ms;
                    if ({1'b0, w.volt_rms} > recover_level &&
                        held_ms >= 32'(lim.good_debounce_ms))
                    begin
                        if (status_now != mqm_pkg::ST_GOOD)
                            recoveries_seen++;
                        status_now = mqm_pkg::ST_GOOD;
                        warn_now = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        r.phase_lock       = lock;
        r.raw_status       = class_now;
        r.debounced_status = status_now;
        r.warn_abnormal    = warn_now;
        r.freq_centihz     = f;
    endtask

    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [4:0] pick_half();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 5'd10;
        else if (r < 80)
            return 5'($urandom_range(9, 11));
        else
            return 5'($urandom_range(mqm_pkg::CROSS_MIN_MS, mqm_pkg::CROSS_MAX_MS));
    endfunction

    // Aim voltages at the current limits' thresholds, inside their good band, or at random.
    function automatic logic [11:0] pick_volt();
        int lo;
        int hi;
        int rec;
        int lb;
        int v;
        int sel;
        lo = int'(lim.volt_low_limit);
        hi = int'(lim.volt_high_limit);
        rec = lo + int'(lim.volt_recovery_margin);
        sel = (healthy && $urandom_range(0, 19) != 0) ? 9 : $urandom_range(0, 9);
        case (sel)
            0: v = int'($urandom_range(0, 4095));
            1: v = int'($urandom_range(0, mqm_pkg::LOST_VOLT));
            2: v = lo + int'($urandom_range(0, 2)) - 1;
            3: v = hi + int'($urandom_range(0, 2)) - 1;
            4: v = rec + int'($urandom_range(0, 2)) - 1;
            default:
            begin
                lb = (rec + 1 > int'(mqm_pkg::LOST_VOLT)) ? rec + 1 : int'(mqm_pkg::LOST_VOLT);
                if (lb <= hi)
                    v = int'($urandom_range(lb, hi));
                else
                    v = int'($urandom_range(0, 4095));
            end
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    // Mostly a steady mains with crossings on time; now and then outages, jitter and noise.
    function automatic mqm_pkg::item_t next_word();
        mqm_pkg::item_t w;
        int             r;
        logic [31:0]    room;
        w.func = mqm_pkg::FUNC_TICK;
        w.now_ms = stamp_ms;
        w.volt_rms = '0;
        if ($urandom_range(0, 99) < (healthy ? 2 : 10))
            healthy = !healthy;
        if ($urandom_range(0, 49) == 0)
            mains_half = pick_half();
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            w.func = FUNC_SPARE;
            w.now_ms = $urandom();
            w.volt_rms = 12'($urandom());
            return w;
        end
        if (r < (healthy ? 3 : 6) ||
            (healthy && stamp_ms - last_cross_ms > mqm_pkg::LOST_MS))
        begin
            // resync crossing timing
            w.func = mqm_pkg::FUNC_INIT;
            w.now_ms = stamp_ms + $urandom_range(0, 3);
            w.volt_rms = 12'($urandom());
        end
        else if (r < 45)
        begin
            w.func = mqm_pkg::FUNC_CROSS;
            w.volt_rms = 12'($urandom());
            r = healthy ? 0 : $urandom_range(0, 19);
            if (r < 14)
                w.now_ms = last_cross_ms + mains_half;
            else if (r < 19)
                w.now_ms = last_cross_ms + $urandom_range(0, 40);
            else
                w.now_ms = $urandom();
        end
        else
        begin
            // most ticks stay ahead of the last crossing but not past the next one
            room = last_cross_ms + mains_half - stamp_ms;
            r = healthy ? 0 : $urandom_range(0, 19);
            if (r < 16)
                w.now_ms = stamp_ms + ((room <= mains_half) ? $urandom_range(0, room) : 0);
            else if (r < 19)
                w.now_ms = stamp_ms + $urandom_range(20, 90);
            else
                w.now_ms = stamp_ms + $urandom_range(100, 5000);
            w.volt_rms = pick_volt();
        end
        stamp_ms = w.now_ms;
        return w;
    endfunction

    task automatic add_row(input logic [1:0] f, input logic [31:0] t, input logic [11:0] v,
                           input bit typed = 1'b0, input mqm_pkg::result_t want = '0);
        stim_row_t row;
        row.word.func = f;
        row.word.now_ms = t;
        row.word.volt_rms = v;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endtask

    // Offer one word, hold it until taken, then log its predicted report.
    task automatic offer_word(input mqm_pkg::item_t w, input bit typed = 1'b0,
                              input mqm_pkg::result_t want = '0);
        mqm_pkg::result_t predicted;
        int               gap;
        item <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        monitor_step(w, predicted);
        predicted_reports.push_back(typed ? want : predicted);
        words_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Write all limits once the pipeline is empty.
    task automatic load_limits(input mqm_pkg::cfg_t c);
        item_valid <= 1'b0;
        while (predicted_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        put_reg(mqm_pkg::REG_VOLT_LOW, 16'(c.volt_low_limit));
        put_reg(mqm_pkg::REG_VOLT_HIGH, 16'(c.volt_high_limit));
        put_reg(mqm_pkg::REG_VOLT_MARGIN, 16'(c.volt_recovery_margin));
        put_reg(mqm_pkg::REG_FREQ_LOW, 16'(c.freq_low_limit));
        put_reg(mqm_pkg::REG_FREQ_HIGH, 16'(c.freq_high_limit));
        put_reg(mqm_pkg::REG_FAIL_DEB, c.fail_debounce_ms);
        put_reg(mqm_pkg::REG_GOOD_DEB, c.good_debounce_ms);
        cfg_we <= 1'b0;
        lim = c;
    endtask

    initial
    begin : stimulus
        mqm_pkg::cfg_t  plan[N_PHASES];
        mqm_pkg::item_t sync_word;
        int             p;
        int             k;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // after reset: good reading, status still unknown
        add_row(mqm_pkg::FUNC_TICK, 32'd0, 12'd2300, 1'b1,
                mqm_pkg::result_t'{1'b0, mqm_pkg::ST_GOOD, mqm_pkg::ST_UNKNOWN, 1'b0,
                                   14'd5000});
        // crossing too early, then shortest, one past longest, longest half-period
        add_row(mqm_pkg::FUNC_CROSS, 32'd5, 12'd0, 1'b1,
                mqm_pkg::result_t'{1'b0, mqm_pkg::ST_GOOD, mqm_pkg::ST_UNKNOWN, 1'b0,
                                   14'd5000});
        add_row(mqm_pkg::FUNC_CROSS, 32'd6, 12'd4095, 1'b1,
                mqm_pkg::result_t'{1'b1, mqm_pkg::ST_GOOD, mqm_pkg::ST_UNKNOWN, 1'b0,
                                   14'd8333});
        add_row(mqm_pkg::FUNC_CROSS, 32'd32, 12'd0, 1'b1,
                mqm_pkg::result_t'{1'b0, mqm_pkg::ST_GOOD, mqm_pkg::ST_UNKNOWN, 1'b0,
                                   14'd8333});
        add_row(mqm_pkg::FUNC_CROSS, 32'd31, 12'd0, 1'b1,
                mqm_pkg::result_t'{1'b1, mqm_pkg::ST_GOOD, mqm_pkg::ST_UNKNOWN, 1'b0,
                                   14'd2000});
        // low voltage is lost; a frequency fault then reports once the fail debounce has run
        add_row(mqm_pkg::FUNC_TICK, 32'd31, 12'd499, 1'b1,
                mqm_pkg::result_t'{1'b0, mqm_pkg::ST_LOST, mqm_pkg::ST_UNKNOWN, 1'b0,
                                   14'd2000});
        add_row(mqm_pkg::FUNC_TICK, 32'd51, 12'd2300, 1'b1,
                mqm_pkg::result_t'{1'b0, mqm_pkg::ST_FREQ, mqm_pkg::ST_FREQ, 1'b1,
                                   14'd2000});
        add_row(mqm_pkg::FUNC_CROSS, 32'd41, 12'd0);
        add_row(mqm_pkg::FUNC_TICK, 32'd102, 12'd2300);
        add_row(mqm_pkg::FUNC_TICK, 32'd101, 12'd1759);
        add_row(mqm_pkg::FUNC_TICK, 32'd101, 12'd2641);
        add_row(mqm_pkg::FUNC_TICK, 32'd101, 12'd1760);
        add_row(mqm_pkg::FUNC_TICK, 32'd101, 12'd2640);
        // unused kind leaves everything alone
        add_row(FUNC_SPARE, 32'hFFFF_FFFF, 12'hFFF, 1'b1,
                mqm_pkg::result_t'{1'b0, mqm_pkg::ST_GOOD, mqm_pkg::ST_HIGH, 1'b1,
                                   14'd5000});
        // crossing interval across the time wrap
        add_row(mqm_pkg::FUNC_INIT, 32'hFFFF_FFF0, 12'd0);
        add_row(mqm_pkg::FUNC_CROSS, 32'd4, 12'd0);
        add_row(mqm_pkg::FUNC_TICK, 32'd64, 12'd4095);
        add_row(mqm_pkg::FUNC_TICK, 32'd64, 12'd0);
        // good period spans an init and recovers just above the margin
        add_row(mqm_pkg::FUNC_INIT, 32'd1000, 12'd0);
        add_row(mqm_pkg::FUNC_CROSS, 32'd1010, 12'd0);
        add_row(mqm_pkg::FUNC_TICK, 32'd1010, 12'd2300);
        add_row(mqm_pkg::FUNC_INIT, 32'd4010, 12'd0);
        add_row(mqm_pkg::FUNC_TICK, 32'd4010, 12'd1811, 1'b1,
                mqm_pkg::result_t'{1'b0, mqm_pkg::ST_GOOD, mqm_pkg::ST_GOOD, 1'b0,
                                   14'd5000});
        foreach (directed_rows[i])
            offer_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        plan[0] = '{12'd1760, 12'd2640, 12'd50, 14'd4500, 14'd5500, 16'd20, 16'd100};
        plan[1] = '{12'd2000, 12'd2400, 12'd100, 14'd4900, 14'd5100, 16'd5, 16'd40};
        plan[2] = '{12'd0, 12'd4095, 12'd0, 14'd0, 14'd10000, 16'd0, 16'd0};
        plan[3] = '{12'd1800, 12'd2600, 12'd0, 14'd4000, 14'd6000, 16'd1, 16'd15};
        plan[4].volt_low_limit       = 12'($urandom_range(500, 2400));
        plan[4].volt_high_limit      = 12'($urandom_range(2000, 4095));
        plan[4].volt_recovery_margin = 12'($urandom_range(0, 200));
        plan[4].freq_low_limit       = 14'($urandom_range(0, 6000));
        plan[4].freq_high_limit      = 14'($urandom_range(4000, 10000));
        plan[4].fail_debounce_ms     = 16'($urandom_range(0, 60));
        plan[4].good_debounce_ms     = 16'($urandom_range(0, 300));
        plan[5] = '{12'd4095, 12'd0, 12'd4095, 14'd10000, 14'd0, 16'd65535, 16'd65535};

        for (p = 0; p < N_PHASES; p++)
        begin
            load_limits(plan[p]);
            stamp_ms = (p == 3) ? 32'hFFFF_FF00 : $urandom();
            mains_half = pick_half();
            healthy = 1'b1;
            sync_word.func = mqm_pkg::FUNC_INIT;
            sync_word.now_ms = stamp_ms;
            sync_word.volt_rms = 12'($urandom());
            offer_word(sync_word);
            for (k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                if (p == 0 && k == 120)
                    hold_request = 1'b1;
                offer_word(next_word());
            end
        end

        item_valid <= 1'b0;
        while (predicted_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d input words: a directed table, then %0d random words",
                 words_sent, RANDOM_PER_PHASE);
        $display("under each of %0d limit settings; saw %0d phase locks, %0d debounced faults,",
                 N_PHASES, locks_seen, faults_seen);
        $display("%0d returns to good and one long output hold.", recoveries_seen);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : result_sink
        int r;
        int held;
        result_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request && !hold_done)
            begin
                // hold off long enough for the block to back up into its input
                result_stall <= 1'b1;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    result_stall <= 1'b0;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
                else if (r < 90)
                begin
                    result_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    result_stall <= 1'b1;
                    repeat ($urandom_range(8, 40)) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_reports
        mqm_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (predicted_reports.size() == 0)
            begin
                $error("result word %h arrived with none pending", result);
                mismatches++;
            end
            else
            begin
                want = predicted_reports.pop_front();
                if (result.phase_lock !== want.phase_lock)
                begin
                    $error("phase_lock: expected %0d, got %0d", want.phase_lock, result.phase_lock);
                    mismatches++;
                end
                if (result.raw_status !== want.raw_status)
                begin
                    $error("raw_status: expected %0d, got %0d", want.raw_status, result.raw_status);
                    mismatches++;
                end
                if (result.debounced_status !== want.debounced_status)
                begin
                    $error("debounced_status: expected %0d, got %0d",
                           want.debounced_status, result.debounced_status);
                    mismatches++;
                end
                if (result.warn_abnormal !== want.warn_abnormal)
                begin
                    $error("warn_abnormal: expected %0d, got %0d",
                           want.warn_abnormal, result.warn_abnormal);
                    mismatches++;
                end
                if (result.freq_centihz !== want.freq_centihz)
                begin
                    $error("freq_centihz: expected %0d, got %0d",
                           want.freq_centihz, result.freq_centihz);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- mains_quality_monitor.f -----
hdl/mqm_pkg.sv
hdl/mqm_core.sv
hdl/mains_quality_monitor.sv
tb/mains_quality_monitor_tb.sv
